/* rtl/i2csrf_pkg.sv */
`timescale 1ns / 1ps

package i2csrf_pkg;

  localparam int REQ_DEPTH = 32;
  localparam int RSP_DEPTH = 32;

  localparam int ADDR_W     = 7;
  localparam int CMD_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int REQ_CNT_W  = $clog2(REQ_DEPTH + 1);
  localparam int RSP_FILL_W = $clog2(RSP_DEPTH + 1);
  localparam int RSP_HEAD_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;

  localparam logic [CMD_W-1:0] CMD_START = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RX    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TX    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DONE  = 3'd5;

  localparam logic [BYTE_W-1:0] ADR_MASK    = 8'hFE;
  localparam logic [BYTE_W-1:0] FRAME_EXTRA = 8'd2;
  localparam logic [ADDR_W-1:0] OWN_ADDR_RST = 7'd8;

  typedef struct packed {
    logic              slave_ack;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              req_valid;
    logic [BYTE_W-1:0] req_byte;
    logic              request_ready;
    logic              busy_res;
    logic              resp_overflow;
  } res_t;

endpackage

/* rtl/i2csrf_if.sv */
`timescale 1ns / 1ps

interface i2csrf_evt_if;
  import i2csrf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;
  logic              master_ack;
  logic [BYTE_W-1:0] status_code;

  modport source (output valid, command, data_byte, master_ack, status_code, input ready);
  modport sink   (input valid, command, data_byte, master_ack, status_code, output ready);
endinterface

interface i2csrf_res_if;
  import i2csrf_pkg::*;
  logic              valid;
  logic              ready;
  logic              slave_ack;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              req_valid;
  logic [BYTE_W-1:0] req_byte;
  logic              request_ready;
  logic              busy_res;
  logic              resp_overflow;

  modport source (output valid, slave_ack, tx_valid, tx_byte, req_valid, req_byte,
                  request_ready, busy_res, resp_overflow, input ready);
  modport sink   (input valid, slave_ack, tx_valid, tx_byte, req_valid, req_byte,
                  request_ready, busy_res, resp_overflow, output ready);
endinterface

interface i2csrf_cfg_if;
  import i2csrf_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/i2c_slave_request_response_framer.sv */
`timescale 1ns / 1ps
// channel  | role   | transfer
// ---------+--------+-------------------------------------------------
// evt      | sink   | one bus or host event: command, data, acks, status
// result   | source | one result per event
// cfg      | sink   | own_address write
//
// One event per cycle while evt.ready is high; its result is registered, in the skid entry if the output is stalled.
// A two-entry output (result register plus skid) keeps evt ready while one
// result waits; evt.ready drops only when both entries are full.
// rst is synchronous: mode idle, counters and checksum zero, address 8.
// The response store has no reset; only written entries are read.

module i2c_slave_request_response_framer (
  input logic           clk,
  input logic           rst,
  i2csrf_evt_if.sink    evt,
  i2csrf_res_if.source  result,
  i2csrf_cfg_if.sink    cfg
);
  import i2csrf_pkg::*;

  localparam int MODE_W = 3;
  localparam int POS_W  = RSP_FILL_W + 1;
  localparam logic [MODE_W-1:0] M_IDLE             = 3'd0;
  localparam logic [MODE_W-1:0] M_RECV_ADR         = 3'd1;
  localparam logic [MODE_W-1:0] M_RECV_DATA        = 3'd2;
  localparam logic [MODE_W-1:0] M_RECV_ADR_RESTART = 3'd3;
  localparam logic [MODE_W-1:0] M_SEND_DATA        = 3'd4;
  localparam logic [MODE_W-1:0] M_SEND_ERROR       = 3'd5;
  localparam logic [MODE_W-1:0] M_SEND_CHKSM       = 3'd6;

  logic [ADDR_W-1:0]     own_address;
  logic [MODE_W-1:0]     mode, mode_next;
  logic [BYTE_W-1:0]     checksum, checksum_next;
  logic [REQ_CNT_W-1:0]  req_count, req_count_next;
  logic [BYTE_W-1:0]     store [RSP_DEPTH];
  logic [RSP_HEAD_W-1:0] head, head_next;
  logic [RSP_FILL_W-1:0] fill, fill_next;
  logic [BYTE_W-1:0]     last_status, last_status_next;

  logic                  out_valid, skid_valid;
  res_t                  out_data, skid_data, res;

  logic                  accept, out_fire, addr_hit, wr_en;
  logic [BYTE_W-1:0]     rd_byte, len;
  logic [RSP_HEAD_W-1:0] head_inc, tail;
  logic [POS_W-1:0]      tail_sum;

  assign accept   = evt.valid && evt.ready;
  assign out_fire = out_valid && result.ready;
  assign addr_hit = (evt.data_byte & ADR_MASK) == ({own_address, 1'b0} & ADR_MASK);
  assign rd_byte  = store[head];
  assign head_inc = (head == RSP_HEAD_W'(RSP_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum = POS_W'(head) + POS_W'(fill);
  assign tail     = (tail_sum >= POS_W'(RSP_DEPTH)) ?
                    RSP_HEAD_W'(tail_sum - POS_W'(RSP_DEPTH)) : RSP_HEAD_W'(tail_sum);
  assign len      = (last_status != '0) ? FRAME_EXTRA : BYTE_W'(fill) + FRAME_EXTRA;

  always_comb begin
    mode_next        = mode;
    checksum_next    = checksum;
    req_count_next   = req_count;
    head_next        = head;
    fill_next        = fill;
    last_status_next = last_status;
    wr_en            = 1'b0;
    res              = '0;
    case (evt.command)
      CMD_START: begin
        if (mode == M_RECV_DATA) begin
          mode_next         = M_RECV_ADR_RESTART;
          head_next         = '0;
          fill_next         = '0;
          last_status_next  = '0;
          res.request_ready = 1'b1;
        end else begin
          mode_next     = M_RECV_ADR;
          checksum_next = '0;
        end
      end
      CMD_STOP: mode_next = M_IDLE;
      CMD_RX: begin
        case (mode)
          M_RECV_ADR: begin
            if (!addr_hit || evt.data_byte[0]) begin
              mode_next = M_IDLE;
            end else begin
              checksum_next  = checksum + evt.data_byte;
              req_count_next = '0;
              mode_next      = M_RECV_DATA;
              res.slave_ack  = 1'b1;
            end
          end
          M_RECV_DATA: begin
            if (req_count >= REQ_CNT_W'(REQ_DEPTH)) begin
              mode_next = M_IDLE;
            end else begin
              req_count_next = req_count + 1'b1;
              checksum_next  = checksum + evt.data_byte;
              res.slave_ack  = 1'b1;
              res.req_valid  = 1'b1;
              res.req_byte   = evt.data_byte;
            end
          end
          M_RECV_ADR_RESTART: begin
            if (!addr_hit || !evt.data_byte[0]) begin
              mode_next = M_IDLE;
            end else begin
              checksum_next = checksum + evt.data_byte + len;
              mode_next     = (len <= FRAME_EXTRA) ? M_SEND_ERROR : M_SEND_DATA;
              res.slave_ack = 1'b1;
              res.tx_valid  = 1'b1;
              res.tx_byte   = len;
            end
          end
          default: mode_next = M_IDLE;
        endcase
      end
      CMD_TX: begin
        if (!evt.master_ack) begin
          mode_next = M_IDLE;
        end else if (mode == M_SEND_DATA && fill != '0) begin
          head_next     = head_inc;
          fill_next     = fill - 1'b1;
          checksum_next = checksum + rd_byte;
          res.tx_valid  = 1'b1;
          res.tx_byte   = rd_byte;
          if (fill == RSP_FILL_W'(1)) mode_next = M_SEND_ERROR;
        end else if (mode == M_SEND_DATA || mode == M_SEND_ERROR) begin
          checksum_next = checksum + last_status;
          res.tx_valid  = 1'b1;
          res.tx_byte   = last_status;
          mode_next     = M_SEND_CHKSM;
        end else if (mode == M_SEND_CHKSM) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = checksum;
          mode_next    = M_IDLE;
        end else begin
          mode_next = M_IDLE;
        end
      end
      CMD_PUSH: begin
        if (fill < RSP_FILL_W'(RSP_DEPTH)) begin
          wr_en     = 1'b1;
          fill_next = fill + 1'b1;
        end else begin
          res.resp_overflow = 1'b1;
        end
      end
      CMD_DONE: last_status_next = evt.status_code;
      default: ;
    endcase
    res.busy_res = (mode_next != M_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= OWN_ADDR_RST;
      mode        <= M_IDLE;
      checksum    <= '0;
      req_count   <= '0;
      head        <= '0;
      fill        <= '0;
      last_status <= '0;
    end else begin
      if (cfg.valid) own_address <= cfg.data;
      if (accept) begin
        mode        <= mode_next;
        checksum    <= checksum_next;
        req_count   <= req_count_next;
        head        <= head_next;
        fill        <= fill_next;
        last_status <= last_status_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) store[tail] <= evt.data_byte;
  end

  // result register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !result.ready) begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= res;
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign evt.ready            = !skid_valid;
  assign cfg.ready            = 1'b1;
  assign result.valid         = out_valid;
  assign result.slave_ack     = out_data.slave_ack;
  assign result.tx_valid      = out_data.tx_valid;
  assign result.tx_byte       = out_data.tx_byte;
  assign result.req_valid     = out_data.req_valid;
  assign result.req_byte      = out_data.req_byte;
  assign result.request_ready = out_data.request_ready;
  assign result.busy_res      = out_data.busy_res;
  assign result.resp_overflow = out_data.resp_overflow;

endmodule

/* rtl/i2csrf_checker.sv */
`timescale 1ns / 1ps

module i2csrf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         evt_valid,
  input logic                         evt_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input i2csrf_pkg::res_t             res_data
);
  import i2csrf_pkg::*;

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // skid fills only on a transfer into a stalled output
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(evt_ready) |-> $past(evt_valid && res_valid && !res_ready))
    else $error("evt ready dropped without a stalled result");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> evt_ready)
    else $error("evt not ready with empty output");

endmodule

bind i2c_slave_request_response_framer i2csrf_checker u_i2csrf_checker (
  .clk       (clk),
  .rst       (rst),
  .evt_valid (evt.valid),
  .evt_ready (evt.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  ({result.slave_ack, result.tx_valid, result.tx_byte, result.req_valid,
               result.req_byte, result.request_ready, result.busy_res,
               result.resp_overflow})
);

/* test/i2csrf_checker.sv */
`timescale 1ns / 1ps

module i2csrf_scoreboard (
  input  logic  clk,
  input  logic  rst,
  i2csrf_evt_if evt,
  i2csrf_res_if result,
  i2csrf_cfg_if cfg,
  output int    fail_count,
  output int    pending
);
  import i2csrf_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE,
    M_RECV_ADR,
    M_RECV_DATA,
    M_ADR_RESTART,
    M_SEND_DATA,
    M_SEND_ERROR,
    M_SEND_CHKSM
  } bus_mode_e;

  bus_mode_e             mode;
  logic [ADDR_W-1:0]     own_addr;
  logic [BYTE_W-1:0]     frame_sum;
  logic [REQ_CNT_W-1:0]  req_count;
  logic [BYTE_W-1:0]     rsp_mem [RSP_DEPTH];
  logic [RSP_HEAD_W-1:0] rsp_head;
  logic [RSP_FILL_W-1:0] rsp_fill;
  logic [BYTE_W-1:0]     host_status;
  res_t                  awaited_results [$];
  int                    errors;

  function automatic logic addr_hit(input logic [BYTE_W-1:0] b);
    return (b & ADR_MASK) == ({own_addr, 1'b0} & ADR_MASK);
  endfunction

  task automatic apply_bus_event(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] d,
                                 input logic mack, input logic [BYTE_W-1:0] st);
    res_t              r;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] b;
    int                pos;
    r = '0;
    case (cmd)
      CMD_START: begin
        if (mode == M_RECV_DATA) begin
          mode = M_ADR_RESTART;
          rsp_head = '0;
          rsp_fill = '0;
          host_status = '0;
          r.request_ready = 1'b1;
        end else begin
          mode = M_RECV_ADR;
          frame_sum = '0;
        end
      end
      CMD_STOP: mode = M_IDLE;
      CMD_RX: begin
        case (mode)
          M_RECV_ADR: begin
            if (addr_hit(d) && !d[0]) begin
              frame_sum = frame_sum + d;
              req_count = '0;
              mode = M_RECV_DATA;
              r.slave_ack = 1'b1;
            end else begin
              mode = M_IDLE;
            end
          end
          M_RECV_DATA: begin
            if (int'(req_count) >= REQ_DEPTH) begin
              mode = M_IDLE;
            end else begin
              req_count = req_count + 1'b1;
              frame_sum = frame_sum + d;
              r.slave_ack = 1'b1;
              r.req_valid = 1'b1;
              r.req_byte = d;
            end
          end
          M_ADR_RESTART: begin
            if (addr_hit(d) && d[0]) begin
              len = (host_status != '0) ? FRAME_EXTRA : BYTE_W'(rsp_fill) + FRAME_EXTRA;
              frame_sum = frame_sum + d + len;
              mode = (len <= FRAME_EXTRA) ? M_SEND_ERROR : M_SEND_DATA;
              r.slave_ack = 1'b1;
              r.tx_valid = 1'b1;
              r.tx_byte = len;
            end else begin
              mode = M_IDLE;
            end
          end
          default: mode = M_IDLE;
        endcase
      end
      CMD_TX: begin
        if (!mack) begin
          mode = M_IDLE;
        end else if (mode == M_SEND_DATA && rsp_fill != '0) begin
          b = rsp_mem[rsp_head];
          rsp_head = RSP_HEAD_W'((int'(rsp_head) + 1) % RSP_DEPTH);
          rsp_fill = rsp_fill - 1'b1;
          frame_sum = frame_sum + b;
          r.tx_valid = 1'b1;
          r.tx_byte = b;
          if (rsp_fill == '0) mode = M_SEND_ERROR;
        end else if (mode == M_SEND_DATA || mode == M_SEND_ERROR) begin
          frame_sum = frame_sum + host_status;
          r.tx_valid = 1'b1;
          r.tx_byte = host_status;
          mode = M_SEND_CHKSM;
        end else if (mode == M_SEND_CHKSM) begin
          r.tx_valid = 1'b1;
          r.tx_byte = frame_sum;
          mode = M_IDLE;
        end else begin
          mode = M_IDLE;
        end
      end
      CMD_PUSH: begin
        if (int'(rsp_fill) < RSP_DEPTH) begin
          pos = (int'(rsp_head) + int'(rsp_fill)) % RSP_DEPTH;
          rsp_mem[pos] = d;
          rsp_fill = rsp_fill + 1'b1;
        end else begin
          r.resp_overflow = 1'b1;
        end
      end
      CMD_DONE: host_status = st;
      default: ;
    endcase
    r.busy_res = (mode != M_IDLE);
    awaited_results.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                      input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      mode = M_IDLE;
      own_addr = OWN_ADDR_RST;
      frame_sum = '0;
      req_count = '0;
      rsp_head = '0;
      rsp_fill = '0;
      host_status = '0;
      awaited_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) own_addr = cfg.data;
      if (evt.valid && evt.ready)
        apply_bus_event(evt.command, evt.data_byte, evt.master_ack, evt.status_code);
      if (result.valid && result.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no event awaiting it");
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("slave_ack", BYTE_W'(want.slave_ack), BYTE_W'(result.slave_ack));
          check_field("tx_valid", BYTE_W'(want.tx_valid), BYTE_W'(result.tx_valid));
          check_field("tx_byte", want.tx_byte, result.tx_byte);
          check_field("req_valid", BYTE_W'(want.req_valid), BYTE_W'(result.req_valid));
          check_field("req_byte", want.req_byte, result.req_byte);
          check_field("request_ready", BYTE_W'(want.request_ready),
                      BYTE_W'(result.request_ready));
          check_field("busy_res", BYTE_W'(want.busy_res), BYTE_W'(result.busy_res));
          check_field("resp_overflow", BYTE_W'(want.resp_overflow),
                      BYTE_W'(result.resp_overflow));
        end
      end
    end
    pending <= awaited_results.size();
    fail_count <= errors;
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import i2csrf_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 470;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   items_sent;
  int   burst_left;
  int   hold_asked;
  int   hold_given;
  logic [ADDR_W-1:0] own_addr;

  i2csrf_evt_if evt_bus ();
  i2csrf_res_if res_bus ();
  i2csrf_cfg_if cfg_bus ();

  i2c_slave_request_response_framer u_dut (
    .clk    (clk),
    .rst    (rst),
    .evt    (evt_bus),
    .result (res_bus),
    .cfg    (cfg_bus)
  );

  i2csrf_scoreboard u_checker (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt_bus),
    .result     (res_bus),
    .cfg        (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // result side: stall pattern changes every span; one long hold-off on request
  initial begin
    int style;
    int span;
    int tick;
    res_bus.ready = 1'b0;
    tick = 0;
    forever begin
      style = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        if (hold_asked != hold_given) begin
          res_bus.ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_given++;
        end
        tick++;
        case (style)
          0: res_bus.ready = 1'b1;
          1: res_bus.ready = 1'($urandom_range(0, 1));
          2: res_bus.ready = ($urandom_range(0, 3) == 0);
          default: res_bus.ready = (tick % 3 != 0);
        endcase
      end
    end
  end

  task automatic bus_event(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                           input logic mack, input logic [BYTE_W-1:0] status);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        evt_bus.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    evt_bus.valid = 1'b1;
    evt_bus.command = cmd;
    evt_bus.data_byte = data;
    evt_bus.master_ack = mack;
    evt_bus.status_code = status;
    do @(posedge clk); while (!evt_bus.ready);
    items_sent++;
  endtask

  task automatic bus_cmd(input logic [CMD_W-1:0] cmd);
    bus_event(cmd, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic bus_rx(input logic [BYTE_W-1:0] b);
    bus_event(CMD_RX, b, 1'($urandom), 8'($urandom));
  endtask

  task automatic bus_tx(input logic ack);
    bus_event(CMD_TX, 8'($urandom), ack, 8'($urandom));
  endtask

  task automatic bus_push(input logic [BYTE_W-1:0] b);
    bus_event(CMD_PUSH, b, 1'($urandom), 8'($urandom));
  endtask

  task automatic bus_done(input logic [BYTE_W-1:0] st);
    bus_event(CMD_DONE, 8'($urandom), 1'($urandom), st);
  endtask

  task automatic drain();
    @(negedge clk);
    evt_bus.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_own_address(input logic [ADDR_W-1:0] a);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.data = a;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
    own_addr = a;
  endtask

  // mostly complete write/read transactions, some noise and broken ones
  task automatic random_transaction();
    int n_req;
    int n_rsp;
    int n_tx;
    int cut;
    logic [BYTE_W-1:0] st;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8))
        bus_event(3'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
    end else begin
      n_req = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 35) : $urandom_range(0, 6);
      n_rsp = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
      st = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
      bus_cmd(CMD_START);
      bus_rx(($urandom_range(0, 9) == 0) ? 8'($urandom) : {own_addr, 1'b0});
      repeat (n_req) bus_rx(8'($urandom));
      if ($urandom_range(0, 19) == 0) bus_cmd(CMD_STOP);
      bus_cmd(CMD_START);
      repeat (n_rsp) bus_push(8'($urandom));
      bus_done(st);
      bus_rx(($urandom_range(0, 9) == 0) ? 8'($urandom) : {own_addr, 1'b1});
      n_tx = ((st != 8'd0) ? 0 : ((n_rsp > RSP_DEPTH) ? RSP_DEPTH : n_rsp)) + 2;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_tx - 1) : -1;
      for (int i = 0; i < n_tx; i++) bus_tx(i != cut);
      if ($urandom_range(0, 3) == 0) bus_tx(1'($urandom));
      bus_cmd(CMD_STOP);
    end
  endtask

  initial begin
    int target;
    logic [ADDR_W-1:0] a;
    rst = 1'b1;
    evt_bus.valid = 1'b0;
    evt_bus.command = CMD_STOP;
    evt_bus.data_byte = '0;
    evt_bus.master_ack = 1'b0;
    evt_bus.status_code = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    items_sent = 0;
    burst_left = 0;
    hold_asked = 0;
    hold_given = 0;
    own_addr = OWN_ADDR_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // protocol errors and unused commands
    bus_cmd(CMD_START);
    bus_rx(8'hFF);
    bus_rx(8'h00);
    bus_cmd(CMD_SPARE_A);
    bus_cmd(CMD_SPARE_B);
    bus_cmd(CMD_START);
    bus_rx({own_addr, 1'b1});
    // full transaction with extreme bytes
    bus_cmd(CMD_START);
    bus_rx({own_addr, 1'b0});
    bus_rx(8'h00);
    bus_rx(8'hFF);
    bus_cmd(CMD_START);
    bus_push(8'h00);
    bus_push(8'hFF);
    bus_done(8'h00);
    bus_rx({own_addr, 1'b1});
    repeat (5) bus_tx(1'b1);
    bus_cmd(CMD_STOP);
    // error status gives a short frame, master NACK ends it
    bus_cmd(CMD_START);
    bus_rx({own_addr, 1'b0});
    bus_cmd(CMD_START);
    bus_done(8'hFF);
    bus_rx({own_addr, 1'b1});
    bus_tx(1'b0);

    for (int p = 0; p < 4; p++) begin
      drain();
      a = (p == 0) ? 7'd0 : (p == 1) ? 7'd127 : 7'($urandom);
      write_own_address(a);
      if (p == 0) hold_asked++;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_transaction();
    end
    drain();

    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
